[sv/utf8_stream_decoder_assert.svh]
// Assertion macros used by the decoder checker.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define U8SD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define U8SD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/u8sd_pkg.sv]
package u8sd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned PAY_W  = 7;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_BAD_CONT = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  // Lead byte classification
  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] len;
    logic [PAY_W-1:0] payload;
  } lead_info_t;

  // One decoded result
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    status_t          status;
    logic [LEN_W-1:0] bytes_used;
  } result_t;

endpackage

[sv/u8sd_lead_decode.sv]
module u8sd_lead_decode
  import u8sd_pkg::*;
(
  input  logic [BYTE_W-1:0] data_byte,
  output lead_info_t        lead
);

  // Sequence length and payload mask from the leading ones of the byte
  always_comb begin
    lead.valid   = 1'b1;
    lead.len     = 3'd1;
    lead.payload = data_byte[PAY_W-1:0];
    casez (data_byte)
      8'b0???????: begin
        lead.len     = 3'd1;
        lead.payload = data_byte[6:0];
      end
      8'b110?????: begin
        lead.len     = 3'd2;
        lead.payload = {2'b00, data_byte[4:0]};
      end
      8'b1110????: begin
        lead.len     = 3'd3;
        lead.payload = {3'b000, data_byte[3:0]};
      end
      8'b11110???: begin
        lead.len     = 3'd4;
        lead.payload = {4'b0000, data_byte[2:0]};
      end
      8'b111110??: begin
        lead.len     = 3'd5;
        lead.payload = {5'b00000, data_byte[1:0]};
      end
      8'b1111110?: begin
        lead.len     = 3'd6;
        lead.payload = {6'b000000, data_byte[0]};
      end
      default: begin
        // continuation byte or 0xFE/0xFF where a lead is expected
        lead.valid   = 1'b0;
        lead.len     = 3'd1;
        lead.payload = '0;
      end
    endcase
  end

endmodule

[sv/u8sd_seq_fsm.sv]
module u8sd_seq_fsm
  import u8sd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last,
  input  lead_info_t        lead,
  output logic              res_valid,
  output result_t           res
);

  logic [CP_W-1:0]  accumulated_value, accumulated_value_next;
  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [LEN_W-1:0] sequence_length, sequence_length_next;
  logic             continuation_error, continuation_error_next;

  logic             is_cont;
  logic [LEN_W-1:0] rem_dec;

  assign is_cont = (data_byte[7:6] == 2'b10);
  assign rem_dec = bytes_remaining - 3'd1;

  // Per-byte sequence step
  always_comb begin
    accumulated_value_next  = accumulated_value;
    bytes_remaining_next    = bytes_remaining;
    sequence_length_next    = sequence_length;
    continuation_error_next = continuation_error;
    res_valid               = 1'b0;
    res.code_point          = '0;
    res.status              = ST_OK;
    res.bytes_used          = 3'd1;

    if (step) begin
      if (bytes_remaining == '0) begin
        // waiting for a lead byte
        if (!lead.valid) begin
          res_valid  = 1'b1;
          res.status = ST_BAD_LEAD;
        end else if (lead.len == 3'd1) begin
          res_valid      = 1'b1;
          res.code_point = {{(CP_W-PAY_W){1'b0}}, lead.payload};
        end else if (last) begin
          res_valid  = 1'b1;
          res.status = ST_TRUNC;
        end else begin
          accumulated_value_next  = {{(CP_W-PAY_W){1'b0}}, lead.payload};
          sequence_length_next    = lead.len;
          bytes_remaining_next    = lead.len - 3'd1;
          continuation_error_next = 1'b0;
        end
      end else begin
        // continuation byte: shift in six bits unless already broken
        continuation_error_next = continuation_error | !is_cont;
        if (is_cont && !continuation_error)
          accumulated_value_next = {accumulated_value[CP_W-7:0], data_byte[5:0]};
        bytes_remaining_next = rem_dec;

        if (rem_dec == '0) begin
          res_valid      = 1'b1;
          res.bytes_used = sequence_length;
          if (continuation_error_next) begin
            res.status = ST_BAD_CONT;
          end else begin
            res.code_point = accumulated_value_next;
          end
        end else if (last) begin
          res_valid      = 1'b1;
          res.status     = ST_TRUNC;
          res.bytes_used = sequence_length - rem_dec;
        end

        if (res_valid) begin
          accumulated_value_next  = '0;
          bytes_remaining_next    = '0;
          sequence_length_next    = '0;
          continuation_error_next = 1'b0;
        end
      end
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulated_value  <= '0;
      bytes_remaining    <= '0;
      sequence_length    <= '0;
      continuation_error <= 1'b0;
    end else begin
      accumulated_value  <= accumulated_value_next;
      bytes_remaining    <= bytes_remaining_next;
      sequence_length    <= sequence_length_next;
      continuation_error <= continuation_error_next;
    end
  end

endmodule

[sv/u8sd_out_reg.sv]
module u8sd_out_reg
  import u8sd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  logic    res_valid,
  input  result_t res,
  output logic    free,
  output logic    m_tvalid,
  input  logic    m_tready,
  output logic [39:0] m_tdata,
  output logic [1:0]  m_tuser
);

  result_t held;

  // slot can take a new result when empty or being drained this cycle
  assign free = !m_tvalid || m_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      held <= res;
    end
  end

  assign m_tdata = {6'b000000, held.bytes_used, held.code_point};
  assign m_tuser = held.status;

endmodule

[sv/utf8_stream_decoder.sv]
// UTF-8 stream decoder, original encoding with sequences of one to six bytes.
// Input channel s_*: one byte of the stream per beat, s_tlast on the final
// byte of a buffer. Output channel m_*: one beat per completed sequence with
// the code point and byte count in m_tdata and the status in m_tuser
// (ok, invalid lead, bad continuation, truncated). Lead and continuation
// bytes that leave a sequence open give no output beat.
// Throughput: one byte per cycle while the result register is free. Each
// accepted byte sits in the input register until the decode step loads the
// result register, so m_tvalid rises once the input register has handed on
// the beat that completes its sequence.
// The input register advances only when the result register is empty or being
// drained, so a stall on m_tready holds the result beat steady and drops
// s_tready as soon as the input register is occupied too; nothing is lost or
// reordered.
// Reset (rst, synchronous, active high) empties both registers and returns
// the decoder to waiting for a lead byte.
module utf8_stream_decoder
  import u8sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_buffer
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [30:0] code_point, [33:31] bytes_used, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              out_free;
  logic              adv;
  lead_info_t        lead;
  logic              res_valid;
  result_t           res;

  assign adv      = in_valid && out_free;
  assign s_tready = !in_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  u8sd_lead_decode u_lead (
    .data_byte (in_byte),
    .lead      (lead)
  );

  u8sd_seq_fsm u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .data_byte (in_byte),
    .last      (in_last),
    .lead      (lead),
    .res_valid (res_valid),
    .res       (res)
  );

  u8sd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (adv),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

[sv/u8sd_checker.sv]
`include "utf8_stream_decoder_assert.svh"

module u8sd_checker
  import u8sd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);

  logic [CP_W-1:0]  cp;
  logic [LEN_W-1:0] used_cnt;

  assign cp       = m_tdata[30:0];
  assign used_cnt = m_tdata[33:31];

  // a stalled result beat holds
  `U8SD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser}), "beat changed under stall")

  // error beats carry no code point
  `U8SD_ASSERT(a_err_zero, (m_tvalid && (m_tuser != ST_OK)) |-> (cp == '0), "code point on error")

  // byte count in range one to six
  `U8SD_ASSERT(a_used_range, m_tvalid |-> (used_cnt != 3'd0) && (used_cnt != 3'd7), "bytes_used out of range")

  // single-byte ok results are seven-bit values
  `U8SD_ASSERT(a_ascii, (m_tvalid && (m_tuser == ST_OK) && (used_cnt == 3'd1)) |-> (cp[30:7] == '0), "wide single byte")

  // no result beat straight after reset
  `U8SD_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result beat after reset")

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (.*);
